@@ hw/rtl/opvu_pkg.sv @@
// Shared constants, register indexes and widths for the orbit particle vertex update.
// No dependencies.
package opvu_pkg;

    localparam int FIELD_W        = 16;
    localparam int VTX_W          = 18;
    localparam int CFG_IDX_W      = 8;
    localparam int PHASE_BITS_DEF = 16;

    localparam logic [15:0] SPEED_RATIO_RST = 16'd256;
    localparam logic [15:0] Y_SCALE_RST     = 16'd16384;

    // quarter-wave sine polynomial, Q14
    localparam logic [15:0] SIN_A   = 16'd25736;
    localparam logic [15:0] SIN_B   = 16'd10583;
    localparam logic [15:0] SIN_C   = 16'd1232;
    localparam logic [14:0] SIN_ONE = 15'd16384;

    localparam logic signed [VTX_W-1:0] V_MAX = 18'sh1FFFF;
    localparam logic signed [VTX_W-1:0] V_MIN = 18'sh20000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SPEED_RATIO = 8'd0,
        CFG_Y_SCALE     = 8'd1
    } t_cfg_idx;

endpackage

@@ hw/rtl/opvu_if.sv @@
// Valid/ready channels for particle requests, vertex results and register writes.
// Depends on opvu_pkg.
interface opvu_in_if;
    logic                               valid;
    logic                               ready;
    logic        [opvu_pkg::FIELD_W-1:0] phase;
    logic        [opvu_pkg::FIELD_W-1:0] phase_speed;
    logic        [opvu_pkg::FIELD_W-1:0] radius;
    logic signed [opvu_pkg::FIELD_W-1:0] rot_cos;
    logic signed [opvu_pkg::FIELD_W-1:0] rot_sin;
    logic signed [opvu_pkg::FIELD_W-1:0] depth_in;
    logic                               last_in;

    modport source (output valid, phase, phase_speed, radius, rot_cos, rot_sin, depth_in,
                    last_in, input ready);
    modport sink   (input valid, phase, phase_speed, radius, rot_cos, rot_sin, depth_in,
                    last_in, output ready);
endinterface

interface opvu_out_if;
    logic                               valid;
    logic                               ready;
    logic        [opvu_pkg::FIELD_W-1:0] new_phase;
    logic signed [opvu_pkg::VTX_W-1:0]   vertex_x;
    logic signed [opvu_pkg::VTX_W-1:0]   vertex_y;
    logic signed [opvu_pkg::FIELD_W-1:0] vertex_z;
    logic                               last_out;

    modport source (output valid, new_phase, vertex_x, vertex_y, vertex_z, last_out,
                    input ready);
    modport sink   (input valid, new_phase, vertex_x, vertex_y, vertex_z, last_out,
                    output ready);
endinterface

interface opvu_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [opvu_pkg::CFG_IDX_W-1:0]      index;
    logic [opvu_pkg::FIELD_W-1:0]        data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ hw/rtl/orbit_particle_vertex_update_top.sv @@
// Orbit particle vertex update: phase advance, polynomial sine/cosine, ellipse and rotation.
// Depends on opvu_pkg and the channel interfaces in opvu_if.
// Pipeline: one register stage per step.
// Throughput: one particle per cycle; each stage holds under backpressure only while full.
// Reset: valid bits clear, speed_ratio returns to 1.0 and the y scale to 1.0.
// Register writes are taken every cycle; ready of the write channel stays high.
module orbit_particle_vertex_update_top #(
    parameter int PHASE_BITS = opvu_pkg::PHASE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    opvu_in_if.sink           i_in,
    opvu_out_if.source        o_out,
    opvu_cfg_if.sink          i_cfg
);

    localparam int NSTG  = 9;
    localparam int SUM_W = 25;

    typedef struct packed {
        logic        [15:0] radius;
        logic        [31:0] re;
        logic signed [15:0] rot_cos;
        logic signed [15:0] rot_sin;
        logic signed [15:0] depth;
        logic               last;
    } t_pass;

    logic [15:0] r_speed_ratio;
    logic [15:0] r_y_scale;

    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_en;

    t_pass       r_pass [NSTG];
    logic [15:0] r_np16 [1:NSTG-1];

    // stage 0
    logic [31:0] r_s0_prod;
    logic [15:0] r_s0_ph;
    // stage 1
    logic [14:0] r_s1_q   [2];
    logic        r_s1_neg [2];
    // stage 2
    logic [14:0] r_s2_q2  [2];
    logic [14:0] r_s2_q   [2];
    logic        r_s2_neg [2];
    // stage 3
    logic [13:0] r_s3_tb  [2];
    logic [14:0] r_s3_q2  [2];
    logic [14:0] r_s3_q   [2];
    logic        r_s3_neg [2];
    // stage 4
    logic [14:0] r_s4_ta  [2];
    logic [14:0] r_s4_q   [2];
    logic        r_s4_neg [2];
    // stage 5, lane 0 sine, lane 1 cosine
    logic signed [15:0] r_s5_sc [2];
    // stage 6
    logic signed [32:0] r_s6_ex;
    logic signed [34:0] r_s6_ey;
    // stage 7
    logic signed [50:0] r_s7_px1, r_s7_px2, r_s7_py1, r_s7_py2;
    // stage 8
    logic signed [17:0] r_s8_vx, r_s8_vy;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed_ratio <= opvu_pkg::SPEED_RATIO_RST;
            r_y_scale     <= opvu_pkg::Y_SCALE_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                opvu_pkg::CFG_SPEED_RATIO: r_speed_ratio <= i_cfg.data;
                opvu_pkg::CFG_Y_SCALE:     r_y_scale     <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // stage enables: a stage loads when empty or when the next one moves
    always_comb begin
        w_en[NSTG-1] = !r_v[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            w_en[k] = !r_v[k] || w_en[k+1];
        end
    end

    assign i_in.ready = w_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_en[0]) begin
                r_v[0] <= i_in.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (w_en[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // stage 0: phase increment product
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s0_prod <= 32'(i_in.phase_speed) * 32'(r_speed_ratio);
            r_s0_ph   <= i_in.phase;
        end
    end

    // stage 1: wrap phase, scale to a 16-bit turn, fold into a quadrant
    logic [SUM_W-1:0]      w_sum;
    logic [PHASE_BITS-1:0] w_np;
    logic [15:0]           w_u;
    logic [15:0]           w_np16;
    logic [15:0]           w_ang [2];

    assign w_sum = 25'(r_s0_ph) + 25'(r_s0_prod[31:8]);
    assign w_np  = w_sum[PHASE_BITS-1:0];

    generate
        if (PHASE_BITS >= 16) begin : g_wide
            assign w_u    = w_np[PHASE_BITS-1 -: 16];
            assign w_np16 = w_np[15:0];
        end else begin : g_narrow
            assign w_u    = {w_np, {(16 - PHASE_BITS){1'b0}}};
            assign w_np16 = 16'(w_np);
        end
    endgenerate

    assign w_ang[0] = w_u;
    assign w_ang[1] = w_u + 16'd16384;

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            for (int l = 0; l < 2; l++) begin
                r_s1_q[l]   <= w_ang[l][14] ? opvu_pkg::SIN_ONE - {1'b0, w_ang[l][13:0]}
                                            : {1'b0, w_ang[l][13:0]};
                r_s1_neg[l] <= w_ang[l][15];
            end
        end
    end

    // side data, radius times y scale and wrapped phase down the pipe
    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_pass[0].radius  <= i_in.radius;
            r_pass[0].re      <= 32'(i_in.radius) * 32'(r_y_scale);
            r_pass[0].rot_cos <= i_in.rot_cos;
            r_pass[0].rot_sin <= i_in.rot_sin;
            r_pass[0].depth   <= i_in.depth_in;
            r_pass[0].last    <= i_in.last_in;
        end
        for (int k = 1; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_pass[k] <= r_pass[k-1];
            end
        end
        if (w_en[1]) begin
            r_np16[1] <= w_np16;
        end
        for (int k = 2; k < NSTG; k++) begin
            if (w_en[k]) begin
                r_np16[k] <= r_np16[k-1];
            end
        end
    end

    // stage 2: q squared
    logic [29:0] w_p2 [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_p2[l] = 30'(r_s1_q[l]) * 30'(r_s1_q[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            for (int l = 0; l < 2; l++) begin
                r_s2_q2[l]  <= w_p2[l][28:14];
                r_s2_q[l]   <= r_s1_q[l];
                r_s2_neg[l] <= r_s1_neg[l];
            end
        end
    end

    // stage 3: B - q2*C
    logic [31:0] w_p3 [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_p3[l] = 32'(r_s2_q2[l]) * 32'(opvu_pkg::SIN_C);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            for (int l = 0; l < 2; l++) begin
                r_s3_tb[l]  <= 14'(32'(opvu_pkg::SIN_B) - (w_p3[l] >> 14));
                r_s3_q2[l]  <= r_s2_q2[l];
                r_s3_q[l]   <= r_s2_q[l];
                r_s3_neg[l] <= r_s2_neg[l];
            end
        end
    end

    // stage 4: A - q2*t
    logic [31:0] w_p4 [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_p4[l] = 32'(r_s3_q2[l]) * 32'(r_s3_tb[l]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            for (int l = 0; l < 2; l++) begin
                r_s4_ta[l]  <= 15'(32'(opvu_pkg::SIN_A) - (w_p4[l] >> 14));
                r_s4_q[l]   <= r_s3_q[l];
                r_s4_neg[l] <= r_s3_neg[l];
            end
        end
    end

    // stage 5: q*t, clamp, quadrant sign
    logic [31:0] w_p5 [2];
    logic [14:0] w_mag [2];

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_p5[l]  = 32'(r_s4_q[l]) * 32'(r_s4_ta[l]);
            w_mag[l] = (w_p5[l][31:14] > 18'(opvu_pkg::SIN_ONE)) ? opvu_pkg::SIN_ONE
                                                                 : w_p5[l][28:14];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            for (int l = 0; l < 2; l++) begin
                r_s5_sc[l] <= r_s4_neg[l] ? -$signed({1'b0, w_mag[l]})
                                          : $signed({1'b0, w_mag[l]});
            end
        end
    end

    // stage 6: ellipse point
    logic signed [32:0] w_ex;
    logic signed [48:0] w_eyp;

    assign w_ex  = 33'($signed({1'b0, r_pass[5].radius})) * 33'(r_s5_sc[1]);
    assign w_eyp = 49'($signed({1'b0, r_pass[5].re})) * 49'(r_s5_sc[0]);

    always_ff @(posedge i_clk) begin
        if (w_en[6]) begin
            r_s6_ex <= w_ex;
            r_s6_ey <= -(35'(w_eyp >>> 14));
        end
    end

    // stage 7: rotation products
    always_ff @(posedge i_clk) begin
        if (w_en[7]) begin
            r_s7_px1 <= 51'(r_pass[6].rot_cos) * 51'(r_s6_ey);
            r_s7_px2 <= 51'(r_pass[6].rot_sin) * 51'(r_s6_ex);
            r_s7_py1 <= 51'(r_pass[6].rot_sin) * 51'(r_s6_ey);
            r_s7_py2 <= 51'(r_pass[6].rot_cos) * 51'(r_s6_ex);
        end
    end

    // stage 8: sum, floor to Q4.13, saturate
    function automatic logic signed [17:0] sat18(input logic signed [51:0] v);
        logic signed [51:0] sh;
        sh = v >>> 29;
        if (sh > 52'(opvu_pkg::V_MAX)) begin
            return opvu_pkg::V_MAX;
        end else if (sh < 52'(opvu_pkg::V_MIN)) begin
            return opvu_pkg::V_MIN;
        end
        return sh[17:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (w_en[8]) begin
            r_s8_vx <= sat18(52'(r_s7_px1) + 52'(r_s7_px2));
            r_s8_vy <= sat18(52'(r_s7_py1) - 52'(r_s7_py2));
        end
    end

    assign o_out.valid     = r_v[NSTG-1];
    assign o_out.new_phase = r_np16[NSTG-1];
    assign o_out.vertex_x  = r_s8_vx;
    assign o_out.vertex_y  = r_s8_vy;
    assign o_out.vertex_z  = r_pass[NSTG-1].depth;
    assign o_out.last_out  = r_pass[NSTG-1].last;

    // checks
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_out.valid)
        else $error("result valid after reset");

    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.ready |-> i_in.ready)
        else $error("input stalled while output drains");

    a_stage0_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[0] && !w_en[0]) |=> (r_v[0] && $stable(r_pass[0]) && $stable(r_s0_prod)))
        else $error("stalled stage 0 lost its contents");

    a_sine_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[5] |-> (r_s5_sc[0] <= 16'sd16384 && r_s5_sc[0] >= -16'sd16384 &&
                    r_s5_sc[1] <= 16'sd16384 && r_s5_sc[1] >= -16'sd16384))
        else $error("sine lane out of range");

endmodule
